### src/assert_macros.svh
// Assertion macros used by the list top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge while reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ilir_pkg.sv
// Package with types, codes and constants of the indexed list.
package ilir_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int POS_W        = 8;
    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 8;
    localparam int GRP_SIZE     = 16;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic [POS_W-1:0]          pos;
        logic signed [DATA_W-1:0]  value;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } state_t;

endpackage

### src/ilir_cell.sv
// One list cell: holds an entry, takes its neighbor's entry on a shift, or the new value on an insert at its index.
module ilir_cell
    import ilir_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CMP_W = POS_W
)
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0] data,
    output logic signed [DATA_W-1:0] sel_data
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic [CMP_W-1:0]         pos_ext;

    assign pos_ext = CMP_W'(cmd.pos);

    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (MY_IDX > pos_ext)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == pos_ext)
                begin
                    data_next = cmd.value;
                end
            end
            CELL_REMOVE:
            begin
                if (MY_IDX >= pos_ext)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign sel_data = (MY_IDX == pos_ext) ? data_reg : '0;

endmodule

### src/ilir_chain.sv
// Row of list cells with a two-level read-out tree whose first level is registered.
module ilir_chain
    import ilir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    output logic signed [DATA_W-1:0] rd_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int NGRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

    logic signed [DATA_W-1:0] data_w [CAPACITY];
    logic signed [DATA_W-1:0] sel_pad [NGRP*GRP_SIZE];
    logic signed [DATA_W-1:0] grp_reg [NGRP];
    logic signed [DATA_W-1:0] grp_next [NGRP];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_w;
        logic signed [DATA_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = cmd.value;
        end
        else
        begin : g_mid_l
            assign left_w = data_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = data_w[i];
        end
        else
        begin : g_mid_r
            assign right_w = data_w[i+1];
        end

        ilir_cell #(
            .INDEX (i),
            .CMP_W (CMP_W)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (data_w[i]),
            .sel_data   (sel_pad[i])
        );
    end

    for (genvar p = CAPACITY; p < NGRP*GRP_SIZE; p++)
    begin : g_pad
        assign sel_pad[p] = '0;
    end

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GRP_SIZE; k++)
            begin
                grp_next[g] = grp_next[g] | sel_pad[g*GRP_SIZE + k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
    end

    always_comb
    begin
        rd_data = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            rd_data = rd_data | grp_reg[g];
        end
    end

endmodule

### src/indexed_list_insert_remove.sv
// Top level of the indexed list: request control, count and result register.
//
// Channel | Dir | Handshake          | Payload
// s_*     | in  | s_tvalid/s_tready  | s_tdata: func, position, value
// m_*     | out | m_tvalid/m_tready  | m_tdata: status, read_value, count
//
// After a request is accepted, the execute step shifts the cell row and registers
// the read tree's first level, and the read step then loads the result register.
// The next request is accepted once the block is back in idle.
// A stalled result register holds the block in its last step until taken.
// Reset clears the count and the handshake state; cell contents are not reset.
module indexed_list_insert_remove
    import ilir_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func[1:0], position[9:2], value[41:10], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], read_value[33:2], count[41:34], zero
);

`include "assert_macros.svh"

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int TOP_W = (CMP_W > COUNT_W) ? CMP_W : COUNT_W;

    state_t state_reg;
    state_t state_next;

    logic [FUNC_W-1:0]        func_reg;
    logic [POS_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic [CNT_W-1:0]         used_count_reg;
    logic [CNT_W-1:0]         used_count_next;
    logic                     m_tvalid_reg;
    logic                     m_tvalid_next;
    logic [STATUS_W-1:0]      out_status_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic [COUNT_W-1:0]       out_count_reg;

    logic                     s_fire;
    logic                     out_load;
    logic                     is_full;
    logic                     is_empty;
    logic [CMP_W-1:0]         cnt_ext;
    logic [CMP_W-1:0]         pos_ext;
    logic [TOP_W-1:0]         cnt_top;
    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] rd_data;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign cnt_ext  = CMP_W'(used_count_reg);
    assign pos_ext  = CMP_W'(pos_reg);
    assign cnt_top  = TOP_W'(used_count_reg);
    assign is_full  = (used_count_reg >= CNT_W'(CAPACITY));
    assign is_empty = (used_count_reg == '0);

    ilir_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .clk     (clk),
        .cmd     (cmd),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        status_next     = ST_OK;
        used_count_next = used_count_reg;
        out_load        = 1'b0;
        cmd.op          = CELL_HOLD;
        cmd.pos         = pos_reg;
        cmd.value       = value_reg;

        unique case (func_reg) inside
            FN_INSERT:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    status_next = ST_BADPOS;
                end
            end
            FN_REMOVE, FN_READ:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (pos_ext >= cnt_ext)
                begin
                    status_next = ST_BADPOS;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_READ;
                if (status_next == ST_OK)
                begin
                    if (func_reg == FN_INSERT)
                    begin
                        cmd.op          = CELL_INSERT;
                        used_count_next = used_count_reg + 1'b1;
                    end
                    else if (func_reg == FN_REMOVE)
                    begin
                        cmd.op          = CELL_REMOVE;
                        used_count_next = used_count_reg - 1'b1;
                    end
                end
            end
            S_READ:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_count_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            func_reg  <= s_tdata[1:0];
            pos_reg   <= s_tdata[9:2];
            value_reg <= s_tdata[41:10];
        end
        if (state_reg == S_EXEC)
        begin
            status_reg <= status_next;
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_value_reg  <= ((func_reg == FN_READ) && (status_reg == ST_OK)) ?
                              rd_data : '0;
            out_count_reg  <= cnt_top[COUNT_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_count_reg, out_value_reg, out_status_reg};

    `ASSERT_CLK(a_count_cap, used_count_reg <= CNT_W'(CAPACITY), "count above capacity")
    `ASSERT_CLK(a_count_quiet, (state_reg != S_EXEC) |=> $stable(used_count_reg), "count moved outside execution")
    `ASSERT_CLK(a_fail_keeps, (state_reg == S_EXEC && status_next != ST_OK) |=> $stable(used_count_reg), "failed request changed count")
    `ASSERT_CLK(a_result_src, $rose(m_tvalid) |-> $past(state_reg) == S_READ, "result without a request")

endmodule
